### sv/mck_pkg.sv
// ----------------------------------------------------------------------------
// mck_pkg
// Shared types, constants and the Morse code table for the character keyer.
// ----------------------------------------------------------------------------
`default_nettype none

package mck_pkg;

  // ASCII codes that bound the mapped character ranges
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_NINE  = 8'h39;
  localparam logic [7:0] ASCII_A     = 8'h41;
  localparam logic [7:0] ASCII_Z     = 8'h5A;

  localparam int          NUM_LETTERS      = 26;
  localparam int          NUM_CODES        = 36;
  localparam int          CODE_IDX_W       = 6;
  localparam int          MAX_SYMS         = 5;
  localparam int          LEN_W            = 3;
  localparam int          UNIT_W           = 12;
  localparam int          DUR_W            = 15;
  localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET = 12'd100;

  // One character code: symbol count, then symbols with bit 0 sent first
  // (1 = dash, 0 = dot).
  typedef struct packed {
    logic [LEN_W-1:0]    len;
    logic [MAX_SYMS-1:0] bits;
  } code_t;

  // Classified character handed from the front end to the sequencer
  typedef struct packed {
    logic                is_space;
    logic                lead_gap;
    logic [LEN_W-1:0]    sym_len;
    logic [MAX_SYMS-1:0] sym_bits;
  } job_t;

  // Segment lengths in units
  typedef enum logic [2:0] {
    U_ONE   = 3'd1,
    U_THREE = 3'd3,
    U_SEVEN = 3'd7
  } units_t;

  // Segment sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SPACE,
    BK_LEAD,
    BK_MARK,
    BK_GAP
  } back_state_t;

  // A-Z, then 0-9
  localparam code_t CODE_TAB [NUM_CODES] = '{
    '{3'd2, 5'b00010}, '{3'd4, 5'b00001}, '{3'd4, 5'b00101}, '{3'd3, 5'b00001},
    '{3'd1, 5'b00000}, '{3'd4, 5'b00100}, '{3'd3, 5'b00011}, '{3'd4, 5'b00000},
    '{3'd2, 5'b00000}, '{3'd4, 5'b01110}, '{3'd3, 5'b00101}, '{3'd4, 5'b00010},
    '{3'd2, 5'b00011}, '{3'd2, 5'b00001}, '{3'd3, 5'b00111}, '{3'd4, 5'b00110},
    '{3'd4, 5'b01011}, '{3'd3, 5'b00010}, '{3'd3, 5'b00000}, '{3'd1, 5'b00001},
    '{3'd3, 5'b00100}, '{3'd4, 5'b01000}, '{3'd3, 5'b00110}, '{3'd4, 5'b01001},
    '{3'd4, 5'b01101}, '{3'd4, 5'b00011},
    '{3'd5, 5'b11111}, '{3'd5, 5'b11110}, '{3'd5, 5'b11100}, '{3'd5, 5'b11000},
    '{3'd5, 5'b10000}, '{3'd5, 5'b00000}, '{3'd5, 5'b00001}, '{3'd5, 5'b00011},
    '{3'd5, 5'b00111}, '{3'd5, 5'b01111}
  };

  // Look up a character; unmapped characters return length zero
  function automatic code_t code_lookup(input logic [7:0] sym);
    logic [7:0] off;
    code_t      code;
    code = '0;
    off  = '0;
    if (sym >= ASCII_A && sym <= ASCII_Z) begin
      off  = sym - ASCII_A;
      code = CODE_TAB[off[CODE_IDX_W-1:0]];
    end else if (sym >= ASCII_ZERO && sym <= ASCII_NINE) begin
      off  = sym - ASCII_ZERO + 8'(NUM_LETTERS);
      code = CODE_TAB[off[CODE_IDX_W-1:0]];
    end
    return code;
  endfunction

endpackage

`default_nettype wire

### sv/morse_character_keyer.sv
// The first segment of a character goes through the job queue and the sequencer state to out_tvalid.
// Throughput: one segment per cycle while out_tready does not stall; a character has 1 to 10
//   segments, and the sequencer returns to idle before it takes the next character.
// A two-entry job queue lets the input side accept while segments are still going out.
// Reset (rst_n low, synchronous): letter gap flag cleared, queue emptied,
//   output idle, unit length set to 100 ticks.
// ----------------------------------------------------------------------------
// morse_character_keyer
// Converts ASCII characters into timed Morse key segments (level, duration).
// ----------------------------------------------------------------------------
`default_nettype none

module morse_character_keyer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] symbol
  input  wire logic        in_tlast,   // end_of_message
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [0] key_on, [15:1] duration
  output logic             out_tlast,  // last_segment
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [11:0] cfg_data    // unit_ticks
);

  logic [mck_pkg::UNIT_W-1:0] unit_ticks_r, unit_ticks_nxt;
  logic                       q_full;
  logic                       push;
  mck_pkg::job_t              push_job;
  logic                       pop;
  logic                       pop_valid;
  mck_pkg::job_t              pop_job;
  logic                       key_on;
  logic [mck_pkg::DUR_W-1:0]  duration;

  // Unit length register
  assign cfg_ready      = 1'b1;
  assign unit_ticks_nxt = (cfg_valid && cfg_ready) ? cfg_data : unit_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r <= mck_pkg::UNIT_TICKS_RESET;
    end else begin
      unit_ticks_r <= unit_ticks_nxt;
    end
  end

  mck_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .symbol         (in_tdata),
    .end_of_message (in_tlast),
    .q_full         (q_full),
    .push           (push),
    .push_job       (push_job)
  );

  mck_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_job   (pop_job)
  );

  mck_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .unit_ticks   (unit_ticks_r),
    .job_valid    (pop_valid),
    .job          (pop_job),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .key_on       (key_on),
    .duration     (duration),
    .last_segment (out_tlast)
  );

  assign out_tdata = {duration, key_on};

endmodule

`default_nettype wire

### sv/mck_front.sv
// ----------------------------------------------------------------------------
// mck_front
// Accepts characters, tracks the owed letter gap and queues segment jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module mck_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    symbol,
  input  wire logic          end_of_message,
  input  wire logic          q_full,
  output logic               push,
  output mck_pkg::job_t      push_job
);

  logic          gap_pending_r;
  logic          gap_pending_nxt;
  logic          accept;
  logic          is_space;
  mck_pkg::code_t code;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_space = (symbol == mck_pkg::ASCII_SPACE);
  assign code     = mck_pkg::code_lookup(symbol);

  // Classify the character into a job; drop items that produce no segment
  always_comb begin
    push_job.is_space = is_space;
    push_job.lead_gap = !is_space && gap_pending_r;
    push_job.sym_len  = is_space ? '0 : code.len;
    push_job.sym_bits = code.bits;
    push = accept && (is_space || gap_pending_r || (code.len != '0));
    gap_pending_nxt = gap_pending_r;
    if (accept) begin
      gap_pending_nxt = is_space ? 1'b0 : !end_of_message;
    end
  end

  // Hold the letter gap flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_pending_r <= 1'b0;
    end else begin
      gap_pending_r <= gap_pending_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/mck_queue.sv
// ----------------------------------------------------------------------------
// mck_queue
// Short job queue that decouples the front end from the segment sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mck_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire mck_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               pop_valid,
  output mck_pkg::job_t      pop_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mck_pkg::job_t   entry_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r,  count_nxt;
  logic            do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_job   = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

### sv/mck_back.sv
// ----------------------------------------------------------------------------
// mck_back
// Segment sequencer: expands one queued job into timed key segments.
// ----------------------------------------------------------------------------
`default_nettype none

module mck_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [mck_pkg::UNIT_W-1:0]   unit_ticks,
  input  wire logic                         job_valid,
  input  wire mck_pkg::job_t                job,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              key_on,
  output logic [mck_pkg::DUR_W-1:0]         duration,
  output logic                              last_segment
);

  mck_pkg::back_state_t state_r, state_nxt;
  mck_pkg::job_t        job_r, job_nxt;
  logic [2:0]           idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 key_r;
  logic [mck_pkg::DUR_W-1:0] dur_r;
  logic                 last_r;
  logic                 out_free;
  logic                 emit;
  logic                 seg_key;
  logic                 seg_last;
  mck_pkg::units_t      seg_units;
  logic                 mark_last;

  // Scale a unit count by the unit length with shifts, adds and a subtract
  function automatic logic [mck_pkg::DUR_W-1:0] scale(
    input mck_pkg::units_t u, input logic [mck_pkg::UNIT_W-1:0] ut);
    logic [mck_pkg::DUR_W-1:0] d;
    case (u)
      mck_pkg::U_ONE:   d = {3'b000, ut};
      mck_pkg::U_THREE: d = {3'b000, ut} + {2'b00, ut, 1'b0};
      mck_pkg::U_SEVEN: d = {ut, 3'b000} - {3'b000, ut};
      default:          d = '0;
    endcase
    return d;
  endfunction

  assign out_free  = !out_valid_r || out_ready;
  assign mark_last = (idx_r == job_r.sym_len - 3'd1);

  // Next state and segment selection
  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    idx_nxt   = idx_r;
    pop       = 1'b0;
    emit      = 1'b0;
    seg_key   = 1'b0;
    seg_last  = 1'b0;
    seg_units = mck_pkg::U_ONE;
    unique case (state_r)
      mck_pkg::BK_IDLE: begin
        if (job_valid) begin
          pop     = 1'b1;
          job_nxt = job;
          idx_nxt = '0;
          if (job.is_space) begin
            state_nxt = mck_pkg::BK_SPACE;
          end else if (job.lead_gap) begin
            state_nxt = mck_pkg::BK_LEAD;
          end else begin
            state_nxt = mck_pkg::BK_MARK;
          end
        end
      end
      mck_pkg::BK_SPACE: begin
        if (out_free) begin
          emit      = 1'b1;
          seg_units = mck_pkg::U_SEVEN;
          seg_last  = 1'b1;
          state_nxt = mck_pkg::BK_IDLE;
        end
      end
      mck_pkg::BK_LEAD: begin
        if (out_free) begin
          emit      = 1'b1;
          seg_units = mck_pkg::U_THREE;
          seg_last  = (job_r.sym_len == '0);
          state_nxt = seg_last ? mck_pkg::BK_IDLE : mck_pkg::BK_MARK;
        end
      end
      mck_pkg::BK_MARK: begin
        if (out_free) begin
          emit      = 1'b1;
          seg_key   = 1'b1;
          seg_units = job_r.sym_bits[idx_r] ? mck_pkg::U_THREE : mck_pkg::U_ONE;
          seg_last  = mark_last;
          state_nxt = mark_last ? mck_pkg::BK_IDLE : mck_pkg::BK_GAP;
        end
      end
      mck_pkg::BK_GAP: begin
        if (out_free) begin
          emit      = 1'b1;
          idx_nxt   = idx_r + 3'd1;
          state_nxt = mck_pkg::BK_MARK;
        end
      end
      default: begin
        state_nxt = mck_pkg::BK_IDLE;
      end
    endcase
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mck_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // Hold the current job and the output segment
  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (emit) begin
      key_r  <= seg_key;
      dur_r  <= scale(seg_units, unit_ticks);
      last_r <= seg_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign key_on       = key_r;
  assign duration     = dur_r;
  assign last_segment = last_r;

endmodule

`default_nettype wire

### sv/mck_checker.sv
// ----------------------------------------------------------------------------
// mck_checker
// Port-level checks on the keyer's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module mck_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast
);

  logic expect_dark_r;

  // Track that a lit segment inside a character owes a dark segment next
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_dark_r <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      expect_dark_r <= out_tdata[0] && !out_tlast;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result transaction dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_dark_after_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && expect_dark_r |-> !out_tdata[0])
    else $error("two lit segments back to back within a character");

endmodule

bind morse_character_keyer mck_checker u_mck_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
